FILE: sv/qem_pkg.sv
package qem_pkg;

    localparam int DW                  = 32;
    localparam int FRAC_BITS           = 30;
    localparam int UNIT_FRAC           = 30;
    localparam int ANG_FRAC            = 40;
    localparam int ANG_SHIFT           = ANG_FRAC - FRAC_BITS;
    localparam int SC_SHIFT            = ANG_FRAC - UNIT_FRAC;
    // A 32-bit root shifted to 40 fraction bits stays below 2*pi, so no modulo stage.
    localparam int ANG_W               = 43;
    localparam int CW                  = 48;
    localparam int TRIG_ITERATIONS_DEF = 30;
    localparam int MAX_ITERS           = 40;
    localparam int SQ_STEPS            = 32;
    localparam int REM_W               = 34;
    localparam int NUM_W               = 62;
    localparam int QUO_W               = 31;
    localparam int DIV_STEPS           = QUO_W;
    localparam int PROD_W              = 64;
    localparam int RND_SHIFT           = 29;
    localparam int SERIES_TERMS        = 40;

    typedef struct packed {
        logic signed [DW-1:0] quat_x_in;
        logic signed [DW-1:0] quat_y_in;
        logic signed [DW-1:0] quat_z_in;
        logic signed [DW-1:0] quat_w_in;
        logic signed [DW-1:0] delta_x;
        logic signed [DW-1:0] delta_y;
        logic signed [DW-1:0] delta_z;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0] quat_x_out;
        logic signed [DW-1:0] quat_y_out;
        logic signed [DW-1:0] quat_z_out;
        logic signed [DW-1:0] quat_w_out;
        logic                 saturated;
    } t_out;

    // The functions below are only evaluated at elaboration to build constants.
    function automatic logic [63:0] c_div(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] c_isqrt(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = x;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] c_atan_recip(input logic [63:0] m);
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] t;
        p = c_div(64'd1 << 60, m);
        s = '0;
        for (int k = 0; k < SERIES_TERMS; k++) begin
            if (p != 64'd0) begin
                t = c_div(p, 64'(2 * k + 1));
                if (k % 2 == 1) begin
                    s = s - t;
                end else begin
                    s = s + t;
                end
                p = c_div(p, m * m);
            end
        end
        return s;
    endfunction

    function automatic logic [63:0] c_atan_pow2(input int i);
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] t;
        p = (64'd1 << 60) >> i;
        s = '0;
        for (int k = 0; k < SERIES_TERMS; k++) begin
            if (p != 64'd0) begin
                t = c_div(p, 64'(2 * k + 1));
                if (k % 2 == 1) begin
                    s = s - t;
                end else begin
                    s = s + t;
                end
                p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
            end
        end
        return s;
    endfunction

    function automatic logic [63:0] c_to40(input logic [63:0] v);
        return (v + (64'd1 << 19)) >> 20;
    endfunction

    function automatic logic [63:0] c_pi4();
        return 64'd4 * c_atan_recip(64'd5) - c_atan_recip(64'd239);
    endfunction

    function automatic logic [63:0] c_atan40(input int i);
        if (i == 0) begin
            return c_to40(c_pi4());
        end
        return c_to40(c_atan_pow2(i));
    endfunction

    // Start value 1/G of the rotation, with 40 fraction bits.
    function automatic logic [63:0] c_cordic_x0(input int iters);
        logic [63:0] g2;
        logic [63:0] g30;
        logic [63:0] k32;
        g2 = 64'd1 << 30;
        for (int i = 0; i < MAX_ITERS; i++) begin
            if (i < iters) begin
                g2 = g2 + (g2 >> (2 * i));
            end
        end
        g30 = c_isqrt(g2 << 30);
        k32 = c_div(64'd1 << 62, g30);
        return k32 << 8;
    endfunction

    localparam logic [ANG_W-1:0] PI40      = ANG_W'(c_to40(c_pi4() * 64'd4));
    localparam logic [ANG_W-1:0] HALF_PI40 = ANG_W'(c_to40(c_pi4() * 64'd2));

endpackage

FILE: sv/qem_cordic.sv
module qem_cordic #(
    parameter int ITERS = qem_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic        [qem_pkg::ANG_W-1:0] i_ang,
    output logic signed [qem_pkg::CW-1:0]    o_cos,
    output logic signed [qem_pkg::CW-1:0]    o_sin
);
    import qem_pkg::*;

    localparam logic signed [CW-1:0] X0 = CW'(c_cordic_x0(ITERS));

    logic signed [CW-1:0] r_x [ITERS];
    logic signed [CW-1:0] r_y [ITERS];
    logic signed [CW-1:0] r_z [ITERS-1];

    for (genvar i = 0; i < ITERS; i++) begin : g_step
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [CW-1:0] z_in;

        if (i == 0) begin : g_first
            assign x_in = X0;
            assign y_in = '0;
            assign z_in = signed'(CW'(i_ang));
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_in[CW-1]) begin
                    r_x[i] <= x_in - (y_in >>> i);
                    r_y[i] <= y_in + (x_in >>> i);
                end else begin
                    r_x[i] <= x_in + (y_in >>> i);
                    r_y[i] <= y_in - (x_in >>> i);
                end
            end
        end

        // The residual angle after the last rotation is not needed.
        if (i < ITERS - 1) begin : g_z
            localparam logic signed [CW-1:0] ATAN = CW'(c_atan40(i));
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[i] <= z_in[CW-1] ? z_in + ATAN : z_in - ATAN;
                end
            end
        end
    end

    assign o_cos = r_x[ITERS-1];
    assign o_sin = r_y[ITERS-1];

endmodule

FILE: sv/qem_div.sv
module qem_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [qem_pkg::NUM_W-1:0]   i_num,
    input  logic [qem_pkg::DW-1:0]      i_den,
    output logic [qem_pkg::QUO_W-1:0]   o_quo
);
    import qem_pkg::*;

    logic [NUM_W-1:0] r_rem [DIV_STEPS-1];
    logic [DW-1:0]    r_den [DIV_STEPS-1];
    logic [QUO_W-1:0] r_quo [DIV_STEPS];

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int B = QUO_W - 1 - j;
        logic [NUM_W-1:0]  rem_in;
        logic [DW-1:0]     den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [PROD_W-1:0] sh;
        logic              ge;

        if (j == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
        end

        assign sh = PROD_W'(den_in) << B;
        assign ge = PROD_W'(rem_in) >= sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= quo_in | (QUO_W'(ge) << B);
            end
        end

        if (j < DIV_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= ge ? rem_in - NUM_W'(sh) : rem_in;
                    r_den[j] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

FILE: sv/quaternion_exp_map_update_top.sv
// Channel   Direction  Valid        Stall         Payload
// input     in         i_in_valid   o_in_stall    i_in_data  (qem_pkg::t_in)
// output    out        o_out_valid  i_out_stall   o_out_data (qem_pkg::t_out)
//
// One transaction is taken every cycle unless a refused result holds the pipeline;
// each passes through the 32-step square root, the CORDIC rotations and the
// 31-step quotient pipelines, one step per stage.
// Reset clears only the stage valid bits. When a result waits with i_out_stall
// high, the whole pipeline holds and o_in_stall is raised.
module quaternion_exp_map_update_top #(
    parameter int TRIG_ITERATIONS = qem_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  qem_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output qem_pkg::t_out o_out_data
);
    import qem_pkg::*;

    localparam int I_SUM = 1;
    localparam int I_N   = I_SUM + SQ_STEPS;
    localparam int I_F1  = I_N + 1;
    localparam int I_F2  = I_F1 + 1;
    localparam int I_CO  = I_F2 + TRIG_ITERATIONS;
    localparam int I_SC  = I_CO + 1;
    localparam int I_MUL = I_SC + 1;
    localparam int I_MAG = I_MUL + 1;
    localparam int I_DIV = I_MAG + DIV_STEPS;
    localparam int I_SGN = I_DIV + 1;
    localparam int I_HP  = I_SGN + 1;
    localparam int I_PS  = I_HP + 1;
    localparam int I_H   = I_PS + 1;
    localparam int I_OUT = I_H + 1;
    localparam int LAT   = I_OUT + 1;

    localparam logic signed [CW-1:0]     UNIT_HALF = CW'(1) << (SC_SHIFT - 1);
    localparam logic signed [CW-1:0]     UNIT_ONE  = CW'(1) << UNIT_FRAC;
    localparam logic signed [DW-1:0]     P_ONE     = DW'(1) << UNIT_FRAC;
    localparam logic signed [PROD_W-1:0] RND_HALF  = PROD_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] SAT_MAX   = (PROD_W'(1) << (DW - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SAT_MIN   = -SAT_MAX - PROD_W'(1);

    typedef struct packed {
        logic signed [DW-1:0] qx;
        logic signed [DW-1:0] qy;
        logic signed [DW-1:0] qz;
        logic signed [DW-1:0] qw;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [DW-1:0] dz;
        logic        [DW-1:0] n;
        logic                 neg_s;
        logic                 neg_c;
        logic signed [DW-1:0] c;
        logic        [2:0]    pneg;
    } t_side;

    function automatic logic signed [DW-1:0] f_unit(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = (v + UNIT_HALF) >>> SC_SHIFT;
        if (t > UNIT_ONE) begin
            t = UNIT_ONE;
        end else if (t < -UNIT_ONE) begin
            t = -UNIT_ONE;
        end
        return DW'(t);
    endfunction

    logic              w_en;
    logic [LAT-1:0]    r_vld;
    t_side             w_side0;
    t_side             n_side [I_H+1];
    t_side             r_side [I_H+1];

    logic [DW-1:0]     w_dmag [3];
    logic [PROD_W-1:0] r_sq [3];
    logic [PROD_W-1:0] r_sum;

    logic [DW-1:0]     r_sq_root [SQ_STEPS];
    logic [REM_W-1:0]  r_sq_rem  [SQ_STEPS-1];
    logic [PROD_W-1:0] r_sq_val  [SQ_STEPS-1];

    logic [ANG_W-1:0]  w_ang;
    logic              w_gt_pi;
    logic              w_gt_half;
    logic [ANG_W-1:0]  r_a1;
    logic [ANG_W-1:0]  r_a2;

    logic signed [CW-1:0]     w_cos;
    logic signed [CW-1:0]     w_sin;
    logic signed [DW-1:0]     r_c30;
    logic signed [DW-1:0]     r_s30;
    logic signed [DW-1:0]     w_d [3];
    logic signed [PROD_W-1:0] r_sd [3];
    logic [NUM_W-1:0]         r_mag [3];
    logic [QUO_W-1:0]         w_quo [3];
    logic signed [DW-1:0]     r_p [3];
    logic signed [PROD_W-1:0] r_hp [4][4];
    logic signed [PROD_W-1:0] r_s1 [4];
    logic signed [PROD_W-1:0] r_s2 [4];
    logic signed [PROD_W-1:0] r_h [4];
    logic signed [PROD_W-1:0] w_r [4];
    logic signed [DW-1:0]     w_res [4];
    logic [3:0]               w_sat;
    t_out                     n_out;
    t_out                     r_out;

    // The pipeline moves as one; it holds only while a finished result is refused.
    assign w_en        = !(r_vld[I_OUT] && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_vld[I_OUT];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_comb begin
        w_side0       = '0;
        w_side0.qx    = i_in_data.quat_x_in;
        w_side0.qy    = i_in_data.quat_y_in;
        w_side0.qz    = i_in_data.quat_z_in;
        w_side0.qw    = i_in_data.quat_w_in;
        w_side0.dx    = i_in_data.delta_x;
        w_side0.dy    = i_in_data.delta_y;
        w_side0.dz    = i_in_data.delta_z;
    end

    // Side data shifts along with the item; some fields are filled in on the way.
    always_comb begin
        n_side[0] = w_side0;
        for (int k = 1; k <= I_H; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[I_F1].n      = r_sq_root[SQ_STEPS-1];
        n_side[I_F1].neg_s  = w_gt_pi;
        n_side[I_F1].neg_c  = w_gt_pi;
        n_side[I_F2].neg_c  = r_side[I_F1].neg_c ^ w_gt_half;
        n_side[I_MUL].c     = r_c30;
        n_side[I_MAG].pneg  = {r_sd[2][PROD_W-1], r_sd[1][PROD_W-1], r_sd[0][PROD_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side <= n_side;
        end
    end

    // Squared length of the increment.
    assign w_dmag[0] = i_in_data.delta_x[DW-1] ? -i_in_data.delta_x : i_in_data.delta_x;
    assign w_dmag[1] = i_in_data.delta_y[DW-1] ? -i_in_data.delta_y : i_in_data.delta_y;
    assign w_dmag[2] = i_in_data.delta_z[DW-1] ? -i_in_data.delta_z : i_in_data.delta_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= PROD_W'(w_dmag[k]) * PROD_W'(w_dmag[k]);
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        logic [DW-1:0]      root_in;
        logic [REM_W-1:0]   rem_in;
        logic [PROD_W-1:0]  val_in;
        logic [REM_W+1:0]   rem_sh;
        logic [REM_W+1:0]   trial;
        logic               ge;

        if (j == 0) begin : g_first
            assign root_in = '0;
            assign rem_in  = '0;
            assign val_in  = r_sum;
        end else begin : g_next
            assign root_in = r_sq_root[j-1];
            assign rem_in  = r_sq_rem[j-1];
            assign val_in  = r_sq_val[j-1];
        end

        assign rem_sh = {rem_in, val_in[PROD_W-1 -: 2]};
        assign trial  = (REM_W+2)'({root_in, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_root[j] <= {root_in[DW-2:0], ge};
            end
        end

        if (j < SQ_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sq_rem[j] <= REM_W'(ge ? rem_sh - trial : rem_sh);
                    r_sq_val[j] <= val_in << 2;
                end
            end
        end
    end

    // Fold the angle into the first quadrant; the sign fix-ups ride in the side data.
    assign w_ang     = ANG_W'({r_sq_root[SQ_STEPS-1], {ANG_SHIFT{1'b0}}});
    assign w_gt_pi   = w_ang > PI40;
    assign w_gt_half = r_a1 > HALF_PI40;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a1 <= w_gt_pi ? w_ang - PI40 : w_ang;
            r_a2 <= w_gt_half ? PI40 - r_a1 : r_a1;
        end
    end

    qem_cordic #(
        .ITERS (TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (r_a2),
        .o_cos (w_cos),
        .o_sin (w_sin)
    );

    assign w_d[0] = r_side[I_SC].dx;
    assign w_d[1] = r_side[I_SC].dy;
    assign w_d[2] = r_side[I_SC].dz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c30 <= r_side[I_CO].neg_c ? -f_unit(w_cos) : f_unit(w_cos);
            r_s30 <= r_side[I_CO].neg_s ? -f_unit(w_sin) : f_unit(w_sin);
            for (int k = 0; k < 3; k++) begin
                r_sd[k]  <= PROD_W'(r_s30) * PROD_W'(w_d[k]);
                r_mag[k] <= NUM_W'(r_sd[k][PROD_W-1] ? -r_sd[k] : r_sd[k]);
            end
        end
    end

    // sin(n)/n scaling: magnitudes are divided, the sign is put back afterwards.
    for (genvar k = 0; k < 3; k++) begin : g_div
        qem_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_mag[k]),
            .i_den (r_side[I_MAG].n),
            .o_quo (w_quo[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= r_side[I_DIV].pneg[k] ? -signed'(DW'(w_quo[k]))
                                                 : signed'(DW'(w_quo[k]));
            end
        end
    end

    // Hamilton product: sixteen partial products, then pair sums, halving and rounding.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hp[0][0] <= PROD_W'(r_side[I_SGN].c) * PROD_W'(r_side[I_SGN].qx);
            r_hp[0][1] <= PROD_W'(r_p[0]) * PROD_W'(r_side[I_SGN].qw);
            r_hp[0][2] <= PROD_W'(r_p[1]) * PROD_W'(r_side[I_SGN].qz);
            r_hp[0][3] <= PROD_W'(r_p[2]) * PROD_W'(r_side[I_SGN].qy);
            r_hp[1][0] <= PROD_W'(r_side[I_SGN].c) * PROD_W'(r_side[I_SGN].qy);
            r_hp[1][1] <= PROD_W'(r_p[1]) * PROD_W'(r_side[I_SGN].qw);
            r_hp[1][2] <= PROD_W'(r_p[2]) * PROD_W'(r_side[I_SGN].qx);
            r_hp[1][3] <= PROD_W'(r_p[0]) * PROD_W'(r_side[I_SGN].qz);
            r_hp[2][0] <= PROD_W'(r_side[I_SGN].c) * PROD_W'(r_side[I_SGN].qz);
            r_hp[2][1] <= PROD_W'(r_p[2]) * PROD_W'(r_side[I_SGN].qw);
            r_hp[2][2] <= PROD_W'(r_p[0]) * PROD_W'(r_side[I_SGN].qy);
            r_hp[2][3] <= PROD_W'(r_p[1]) * PROD_W'(r_side[I_SGN].qx);
            r_hp[3][0] <= PROD_W'(r_side[I_SGN].c) * PROD_W'(r_side[I_SGN].qw);
            r_hp[3][1] <= PROD_W'(r_p[0]) * PROD_W'(r_side[I_SGN].qx);
            r_hp[3][2] <= PROD_W'(r_p[1]) * PROD_W'(r_side[I_SGN].qy);
            r_hp[3][3] <= PROD_W'(r_p[2]) * PROD_W'(r_side[I_SGN].qz);

            for (int c = 0; c < 3; c++) begin
                r_s1[c] <= r_hp[c][0] + r_hp[c][1];
                r_s2[c] <= r_hp[c][2] - r_hp[c][3];
            end
            r_s1[3] <= r_hp[3][0] - r_hp[3][1];
            r_s2[3] <= -r_hp[3][2] - r_hp[3][3];

            for (int c = 0; c < 4; c++) begin
                r_h[c] <= (r_s1[c] >>> 1) + (r_s2[c] >>> 1);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_r[c] = (r_h[c] + RND_HALF) >>> RND_SHIFT;
            if (w_r[c] > SAT_MAX) begin
                w_res[c] = DW'(SAT_MAX);
                w_sat[c] = 1'b1;
            end else if (w_r[c] < SAT_MIN) begin
                w_res[c] = DW'(SAT_MIN);
                w_sat[c] = 1'b1;
            end else begin
                w_res[c] = DW'(w_r[c]);
                w_sat[c] = 1'b0;
            end
        end

        // A zero increment leaves the quaternion as it was.
        if (r_side[I_H].n == '0) begin
            n_out.quat_x_out = r_side[I_H].qx;
            n_out.quat_y_out = r_side[I_H].qy;
            n_out.quat_z_out = r_side[I_H].qz;
            n_out.quat_w_out = r_side[I_H].qw;
            n_out.saturated  = 1'b0;
        end else begin
            n_out.quat_x_out = w_res[0];
            n_out.quat_y_out = w_res[1];
            n_out.quat_z_out = w_res[2];
            n_out.quat_w_out = w_res[3];
            n_out.saturated  = |w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a refused result transaction");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[I_F2] |-> (r_a2 <= HALF_PI40))
        else $error("folded angle outside the first quadrant");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[I_SGN] && (r_side[I_SGN].n != '0)) |->
            ((r_p[0] <= P_ONE) && (r_p[0] >= -P_ONE) &&
             (r_p[1] <= P_ONE) && (r_p[1] >= -P_ONE) &&
             (r_p[2] <= P_ONE) && (r_p[2] >= -P_ONE)))
        else $error("rotation vector part exceeds unit magnitude");

endmodule
